### hw/rtl/i2p_pkg.sv
// Shared types, codes and constants for the infix-to-prefix converter.
// No dependencies; imported by the top level, the sequencer and the output buffer.
package i2p_pkg;

	localparam int STACK_DEPTH_DEF = 32;

	localparam logic [7:0] CH_ADD  = 8'h2B;
	localparam logic [7:0] CH_SUB  = 8'h2D;
	localparam logic [7:0] CH_MUL  = 8'h2A;
	localparam logic [7:0] CH_DIV  = 8'h2F;
	localparam logic [7:0] CH_LPAR = 8'h28;
	localparam logic [7:0] CH_RPAR = 8'h29;

	typedef enum logic [2:0] {
		OP_RPAR = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_code_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_OVF  = 2'd1,
		ERR_UNF  = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		ACT_OP,
		ACT_UNWIND,
		ACT_FLUSH
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_PUSH,
		ST_CHAR,
		ST_FIN
	} st_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       has_char;
		logic       last;
		err_t       err;
	} res_t;

	function automatic logic [7:0] code_char(input op_code_t code);
		logic [7:0] c;
		case (code)
			OP_ADD:  c = CH_ADD;
			OP_SUB:  c = CH_SUB;
			OP_MUL:  c = CH_MUL;
			OP_DIV:  c = CH_DIV;
			default: c = CH_RPAR;
		endcase
		return c;
	endfunction

	function automatic logic is_high(input op_code_t code);
		return (code == OP_MUL) || (code == OP_DIV);
	endfunction

endpackage

### hw/rtl/infix_to_prefix_converter.sv
// Top level of the infix-to-prefix converter: sequencer, stack RAM, output buffer.
// Depends on i2p_pkg, i2p_seq, i2p_stack_ram, i2p_out_buf.
//
//   channel  | dir | tdata                 | tuser    | tlast
//   s_*      | in  | [7:0] ch              | kind     | -
//   m_*      | out | [7:0] out_char, [9:8] | has_char | last
//            |     | error_code            |          |
//
// An operand passes through ST_CHAR, ')' through ST_PUSH. An operator pops in
// ST_READ while needed, then goes to ST_PUSH; '(' pops in ST_READ, and the end
// word pops in ST_READ and then finishes in ST_FIN. Each pop waits for the new top
// from the registered stack RAM read port. Reset leaves the lone ')' sentinel on
// the stack; no clearing pass. A stalled master side holds the sequencer whenever it
// has a word to hand on, until the output register frees.
module infix_to_prefix_converter #(
	parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_char, [9:8] error_code, [15:10] zero
	output logic        m_tuser,   // has_char
	output logic        m_tlast    // last
);
	import i2p_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int TW = $clog2(STACK_DEPTH + 1);

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [2:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [2:0]    ram_rdata;
	logic          out_free;
	logic          out_load;
	res_t          out_res;

	i2p_seq #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW),
		.TW    (TW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.in_ch     (s_tdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_free  (out_free),
		.out_load  (out_load),
		.out_res   (out_res)
	);

	i2p_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	i2p_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.res      (out_res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### hw/rtl/i2p_stack_ram.sv
// Operator stack storage: one write port, one read port, registered read data.
// No package dependencies.
module i2p_stack_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [2:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [2:0]    rdata
);

	logic [2:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/i2p_out_buf.sv
// Output word register between the sequencer and the master stream port.
// Depends on i2p_pkg (res_t).
module i2p_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  i2p_pkg::res_t res,
	output logic          free,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [15:0]   m_tdata,  // [7:0] out_char, [9:8] error_code, [15:10] zero
	output logic          m_tuser,  // has_char
	output logic          m_tlast   // last
);
	import i2p_pkg::*;

	logic valid_q;
	res_t res_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {6'b0, res_q.err, res_q.out_char};
	assign m_tuser  = res_q.has_char;
	assign m_tlast  = res_q.last;

endmodule

### hw/rtl/i2p_seq.sv
// Sequencer: decodes input words, walks the operator stack through the RAM
// (writes on push, pointer moves on pop) and hands results to the output buffer.
// Depends on i2p_pkg.
module i2p_seq #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int TW    = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          in_kind,
	input  logic [7:0]    in_ch,
	output logic          ram_we,
	output logic [AW-1:0] ram_waddr,
	output logic [2:0]    ram_wdata,
	output logic [AW-1:0] ram_raddr,
	input  logic [2:0]    ram_rdata,
	input  logic          out_free,
	output logic          out_load,
	output i2p_pkg::res_t out_res
);
	import i2p_pkg::*;

	localparam logic [TW-1:0] TOP_FULL = TW'(DEPTH);
	localparam logic [TW-1:0] TOP_ONE  = TW'(1);

	st_t          st_q, st_d;
	logic [TW-1:0] top_q, top_d, top_dm1;
	err_t         err_q, err_d;
	logic         bot_q, bot_d;
	logic         hv_q, hv_d;
	logic         fin_err_q, fin_err_d;
	act_t         act_q, act_d;
	op_code_t     code_q, code_d;
	logic [7:0]   ch_q, ch_d;
	res_t         hold_q, hold_d;

	op_code_t     tos;
	logic         top_empty;
	err_t         err_unf, err_ovf;

	// entry 0 reads as the sentinel until a push lands there
	assign tos       = (top_q == TOP_ONE && !bot_q) ? OP_RPAR : op_code_t'(ram_rdata);
	assign top_empty = (top_q == '0);
	assign err_unf   = (err_q == ERR_NONE) ? ERR_UNF : err_q;
	assign err_ovf   = (err_q == ERR_NONE) ? ERR_OVF : err_q;
	assign in_ready  = (st_q == ST_IDLE);

	assign top_dm1   = top_d - TOP_ONE;
	assign ram_raddr = (top_d == '0) ? '0 : top_dm1[AW-1:0];
	assign ram_waddr = top_q[AW-1:0];
	assign ram_wdata = code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			top_q     <= TOP_ONE;
			err_q     <= ERR_NONE;
			bot_q     <= 1'b0;
			hv_q      <= 1'b0;
			fin_err_q <= 1'b0;
		end else begin
			st_q      <= st_d;
			top_q     <= top_d;
			err_q     <= err_d;
			bot_q     <= bot_d;
			hv_q      <= hv_d;
			fin_err_q <= fin_err_d;
		end
	end

	always_ff @(posedge clk) begin
		act_q  <= act_d;
		code_q <= code_d;
		ch_q   <= ch_d;
		hold_q <= hold_d;
	end

	always_comb begin
		st_d      = st_q;
		top_d     = top_q;
		err_d     = err_q;
		bot_d     = bot_q;
		hv_d      = hv_q;
		fin_err_d = fin_err_q;
		act_d     = act_q;
		code_d    = code_q;
		ch_d      = ch_q;
		hold_d    = hold_q;
		ram_we    = 1'b0;
		out_load  = 1'b0;
		out_res   = '0;

		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					ch_d = in_ch;
					if (in_kind) begin
						act_d = ACT_FLUSH;
						st_d  = ST_READ;
					end else begin
						case (in_ch)
							CH_ADD: begin
								act_d = ACT_OP; code_d = OP_ADD; st_d = ST_READ;
							end
							CH_SUB: begin
								act_d = ACT_OP; code_d = OP_SUB; st_d = ST_READ;
							end
							CH_MUL: begin
								act_d = ACT_OP; code_d = OP_MUL; st_d = ST_READ;
							end
							CH_DIV: begin
								act_d = ACT_OP; code_d = OP_DIV; st_d = ST_READ;
							end
							CH_RPAR: begin
								code_d = OP_RPAR; st_d = ST_PUSH;
							end
							CH_LPAR: begin
								act_d = ACT_UNWIND; st_d = ST_READ;
							end
							default: begin
								st_d = ST_CHAR;
							end
						endcase
					end
				end
			end
			ST_CHAR: begin
				if (out_free) begin
					out_load = 1'b1;
					out_res  = '{out_char: ch_q, has_char: 1'b1, last: 1'b0, err: err_q};
					st_d     = ST_IDLE;
				end
			end
			ST_PUSH: begin
				if (top_q == TOP_FULL) begin
					if (out_free) begin
						out_load = 1'b1;
						out_res  = '{out_char: 8'h00, has_char: 1'b0, last: 1'b0, err: err_ovf};
						err_d    = err_ovf;
						st_d     = ST_IDLE;
					end
				end else begin
					ram_we = 1'b1;
					top_d  = top_q + TOP_ONE;
					if (top_empty) begin
						bot_d = 1'b1;
					end
					st_d = ST_IDLE;
				end
			end
			ST_READ: begin
				case (act_q)
					ACT_OP: begin
						if (top_empty || tos == OP_RPAR || !is_high(tos) || is_high(code_q)) begin
							st_d = ST_PUSH;
						end else if (out_free) begin
							out_load = 1'b1;
							out_res  = '{out_char: code_char(tos), has_char: 1'b1,
								last: 1'b0, err: err_q};
							top_d    = top_q - TOP_ONE;
						end
					end
					ACT_UNWIND: begin
						if (top_empty) begin
							if (out_free) begin
								out_load = 1'b1;
								out_res  = '{out_char: 8'h00, has_char: 1'b0,
									last: 1'b0, err: err_unf};
								err_d    = err_unf;
								st_d     = ST_IDLE;
							end
						end else if (tos == OP_RPAR) begin
							top_d = top_q - TOP_ONE;
							st_d  = ST_IDLE;
						end else if (out_free) begin
							out_load = 1'b1;
							out_res  = '{out_char: code_char(tos), has_char: 1'b1,
								last: 1'b0, err: err_q};
							top_d    = top_q - TOP_ONE;
						end
					end
					ACT_FLUSH: begin
						// one word held back so the final one can carry last
						if (top_empty) begin
							fin_err_d = 1'b1;
							err_d     = err_unf;
							st_d      = ST_FIN;
						end else if (tos == OP_RPAR) begin
							fin_err_d = 1'b0;
							st_d      = ST_FIN;
						end else if (!hv_q || out_free) begin
							out_load = hv_q;
							out_res  = hold_q;
							hold_d   = '{out_char: code_char(tos), has_char: 1'b1,
								last: 1'b0, err: err_q};
							hv_d     = 1'b1;
							top_d    = top_q - TOP_ONE;
						end
					end
					default: begin
						st_d = ST_IDLE;
					end
				endcase
			end
			ST_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					if (hv_q) begin
						out_res      = hold_q;
						out_res.last = !fin_err_q;
						hv_d         = 1'b0;
					end else begin
						out_res = '{out_char: 8'h00, has_char: 1'b0, last: 1'b1, err: err_q};
					end
					if (!hv_q || !fin_err_q) begin
						top_d = TOP_ONE;
						bot_d = 1'b0;
						err_d = ERR_NONE;
						st_d  = ST_IDLE;
					end
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/i2p_checker.sv
// Port-level checks for the infix-to-prefix converter, bound to the top level.
// Depends on infix_to_prefix_converter port names only.
module i2p_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	logic [1:0] seen_q;
	logic       m_acc;

	assign m_acc = m_tvalid && m_tready;

	// sticky error of the current expression, as seen on the port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 2'd0;
		end else if (m_acc) begin
			seen_q <= m_tlast ? 2'd0 : m_tdata[9:8];
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

	a_nochar: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'h00)
		else $error("out_char not zero on a word without character");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[9:8] != 2'd3 && m_tdata[15:10] == 6'd0)
		else $error("bad error code or padding");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && seen_q != 2'd0 |-> m_tdata[9:8] == seen_q)
		else $error("error code dropped before end of expression");

	a_errword: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[7:0] != 8'h28)
		else $error("left parenthesis emitted");

endmodule

bind infix_to_prefix_converter i2p_checker u_chk (.*);

### dv/infix_to_prefix_converter_tb.sv
// Self-checking testbench for infix_to_prefix_converter: a directed table, then random
// expressions fed right to left plus stray words, each output word checked against an operator-stack predictor.
// Depends on i2p_pkg and the RTL of the block; no files or arguments.
module infix_to_prefix_converter_tb;
	import i2p_pkg::*;

	localparam int DEPTH    = STACK_DEPTH_DEF;
	localparam int N_RANDOM = 400;
	localparam int MAX_GAP  = 18;
	localparam int WATCHDOG = 4000;
	localparam int TAIL     = 64;
	localparam int MAX_MSGS = 30;

	typedef struct {
		logic       kind;
		logic [7:0] ch;
		int         reps;
		bit         typed;
		res_t       want;
	} step_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] ch
	logic        s_tuser;   // kind
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [7:0] out_char, [9:8] error_code, [15:10] zero
	logic        m_tuser;   // has_char
	logic        m_tlast;   // last

	// predictor state
	op_code_t    opstk [DEPTH];
	int unsigned sp;
	err_t        err_now;
	res_t        prefix_q [$];

	int n_items, n_results, n_bad, n_ovf, n_unf, idle_cycles;
	bit s_calm, m_calm;
	res_t got, want;
	step_row_t plan [$];

	infix_to_prefix_converter #(.STACK_DEPTH(DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] op_char(op_code_t c);
		case (c)
			OP_ADD:  return CH_ADD;
			OP_SUB:  return CH_SUB;
			OP_MUL:  return CH_MUL;
			OP_DIV:  return CH_DIV;
			default: return CH_RPAR;
		endcase
	endfunction

	function automatic bit binds_tight(op_code_t c);
		return c == OP_MUL || c == OP_DIV;
	endfunction

	function automatic bit is_special(logic [7:0] c);
		return c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV ||
			c == CH_LPAR || c == CH_RPAR;
	endfunction

	function automatic void conv_clear();
		for (int i = 0; i < DEPTH; i++)
			opstk[i] = OP_RPAR;
		sp = 1;
		err_now = ERR_NONE;
	endfunction

	function automatic void emit(logic [7:0] c, logic has);
		res_t r;
		r.out_char = c;
		r.has_char = has;
		r.last = 1'b0;
		r.err = err_now;
		prefix_q.push_back(r);
	endfunction

	function automatic void raise(err_t e);
		if (err_now == ERR_NONE)
			err_now = e;
	endfunction

	function automatic void push_op(op_code_t c);
		if (sp >= DEPTH) begin
			n_ovf++;
			raise(ERR_OVF);
			emit(8'h00, 1'b0);
		end else begin
			opstk[sp] = c;
			sp++;
		end
	endfunction

	// pop and emit down to the nearest ')'; 0 if none was stacked
	function automatic bit unwind();
		op_code_t t;
		while (sp > 0) begin
			sp--;
			t = opstk[sp];
			if (t == OP_RPAR)
				return 1'b1;
			emit(op_char(t), 1'b1);
		end
		return 1'b0;
	endfunction

	function automatic void prefix_step(logic kind, logic [7:0] c);
		int n0;
		op_code_t code;
		op_code_t t;
		res_t r;
		n0 = prefix_q.size();
		if (kind) begin
			if (!unwind()) begin
				n_unf++;
				raise(ERR_UNF);
				emit(8'h00, 1'b0);
			end
			if (prefix_q.size() == n0)
				emit(8'h00, 1'b0);
			r = prefix_q.pop_back();
			r.last = 1'b1;
			prefix_q.push_back(r);
			conv_clear();
			return;
		end
		if (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV) begin
			code = (c == CH_ADD) ? OP_ADD : (c == CH_SUB) ? OP_SUB :
				(c == CH_MUL) ? OP_MUL : OP_DIV;
			while (sp > 0) begin
				t = opstk[sp - 1];
				if (t == OP_RPAR || !binds_tight(t) || binds_tight(code))
					break;
				sp--;
				emit(op_char(t), 1'b1);
			end
			push_op(code);
		end else if (c == CH_RPAR) begin
			push_op(OP_RPAR);
		end else if (c == CH_LPAR) begin
			if (!unwind()) begin
				n_unf++;
				raise(ERR_UNF);
				emit(8'h00, 1'b0);
			end
		end else begin
			emit(c, 1'b1);
		end
	endfunction

	function automatic void add_row(logic kind, logic [7:0] c, int reps, bit typed,
		logic [7:0] oc, logic has, logic lst, err_t e);
		step_row_t row;
		row.kind = kind;
		row.ch = c;
		row.reps = reps;
		row.typed = typed;
		row.want.out_char = oc;
		row.want.has_char = has;
		row.want.last = lst;
		row.want.err = e;
		plan.push_back(row);
	endfunction

	function automatic logic [7:0] rand_operand();
		logic [7:0] c;
		if ($urandom_range(0, 3) == 0) begin
			do
				c = 8'($urandom_range(0, 255));
			while (is_special(c));
		end else begin
			c = 8'h61 + 8'($urandom_range(0, 25));
		end
		return c;
	endfunction

	function automatic logic [7:0] rand_op();
		case ($urandom_range(0, 3))
			0:       return CH_ADD;
			1:       return CH_SUB;
			2:       return CH_MUL;
			default: return CH_DIV;
		endcase
	endfunction

	task automatic report(string what, logic [31:0] g, logic [31:0] w);
		n_bad++;
		if (n_bad <= MAX_MSGS)
			$display("mismatch at word %0d: %s got 0x%0h want 0x%0h", n_results, what, g, w);
	endtask

	// one input word; returns how many results the predictor queued for it
	task automatic feed(input logic kind, input logic [7:0] c, output int added);
		int gap;
		int n0;
		if ($urandom_range(0, 39) == 0)
			s_calm = !s_calm;
		gap = s_calm ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= c;
		do @(posedge clk); while (!s_tready);
		n0 = prefix_q.size();
		prefix_step(kind, c);
		added = prefix_q.size() - n0;
		n_items++;
	endtask

	// receiver: random stall before each word
	initial begin
		int gap;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 39) == 0)
				m_calm = !m_calm;
			gap = m_calm ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.out_char = m_tdata[7:0];
			got.err = err_t'(m_tdata[9:8]);
			got.has_char = m_tuser;
			got.last = m_tlast;
			if (prefix_q.size() == 0) begin
				report("unexpected word, out_char", 32'(got.out_char), 32'd0);
			end else begin
				want = prefix_q.pop_front();
				if (got.out_char !== want.out_char)
					report("out_char", 32'(got.out_char), 32'(want.out_char));
				if (got.has_char !== want.has_char)
					report("has_char", 32'(got.has_char), 32'(want.has_char));
				if (got.last !== want.last)
					report("last", 32'(got.last), 32'(want.last));
				if (got.err !== want.err)
					report("error_code", 32'(got.err), 32'(want.err));
				if (m_tdata[15:10] !== 6'd0)
					report("tdata pad", 32'(m_tdata[15:10]), 32'd0);
			end
			n_results++;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
				WATCHDOG, prefix_q.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int added;
		int rnd_start;
		int depth;
		int len;
		int maxlen;
		int nwrap;
		int idx;
		bit need_opnd;
		bit no_end;
		logic [7:0] infix [$];

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = 1'b0;
		conv_clear();

		// end on a fresh stack, operand extremes, lone '(' cases
		add_row(1'b1, 8'h00, 1, 1'b1, 8'h00, 1'b0, 1'b1, ERR_NONE);
		add_row(1'b0, "x",   1, 1'b1, "x",   1'b1, 1'b0, ERR_NONE);
		add_row(1'b0, 8'hFF, 1, 1'b1, 8'hFF, 1'b1, 1'b0, ERR_NONE);
		add_row(1'b0, 8'h00, 1, 1'b1, 8'h00, 1'b1, 1'b0, ERR_NONE);
		add_row(1'b0, CH_LPAR, 1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
		add_row(1'b0, CH_LPAR, 1, 1'b1, 8'h00, 1'b0, 1'b0, ERR_UNF);
		add_row(1'b1, 8'h00, 1, 1'b1, 8'h00, 1'b0, 1'b1, ERR_UNF);
		// a+b*c-d/e, right to left
		add_row(1'b0, "e",    1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
		add_row(1'b0, CH_DIV, 1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
		add_row(1'b0, "d",    1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
		add_row(1'b0, CH_SUB, 1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
		add_row(1'b0, "c",    1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
		add_row(1'b0, CH_MUL, 1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
		add_row(1'b0, "b",    1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
		add_row(1'b0, CH_ADD, 1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
		add_row(1'b0, "a",    1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
		add_row(1'b1, 8'h00,  1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
		// fill the stack past full, then an operator on a full stack
		add_row(1'b0, CH_RPAR, DEPTH, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
		add_row(1'b0, CH_MUL,  1, 1'b1, 8'h00, 1'b0, 1'b0, ERR_OVF);
		add_row(1'b1, 8'hFF,   1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
		// operator pushed onto an empty stack, end finds no ')'
		add_row(1'b0, CH_LPAR, 1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
		add_row(1'b0, CH_ADD,  1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);
		add_row(1'b1, 8'h55,   1, 1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			for (int r = 0; r < plan[i].reps; r++) begin
				feed(plan[i].kind, plan[i].ch, added);
				if (plan[i].typed) begin
					repeat (added) void'(prefix_q.pop_back());
					prefix_q.push_back(plan[i].want);
				end
			end
		end

		rnd_start = n_items;
		while (n_items - rnd_start < N_RANDOM) begin
			if ($urandom_range(0, 9) == 0) begin
				feed(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), added);
				continue;
			end
			// well-formed infix, left to right
			infix.delete();
			depth = 0;
			len = 0;
			need_opnd = 1'b1;
			maxlen = $urandom_range(1, 24);
			forever begin
				if (need_opnd) begin
					if (depth < 6 && $urandom_range(0, 3) == 0) begin
						infix.push_back(CH_LPAR);
						depth++;
					end else begin
						infix.push_back(rand_operand());
						need_opnd = 1'b0;
					end
				end else if (depth > 0 && ($urandom_range(0, 2) == 0 || len >= maxlen)) begin
					infix.push_back(CH_RPAR);
					depth--;
				end else if (len >= maxlen) begin
					break;
				end else begin
					infix.push_back(rand_op());
					need_opnd = 1'b1;
				end
				len++;
			end
			// deep nesting, past the stack depth at times
			if ($urandom_range(0, 9) == 0) begin
				nwrap = $urandom_range(DEPTH - 6, DEPTH + 4);
				repeat (nwrap) begin
					infix.push_front(CH_LPAR);
					infix.push_back(CH_RPAR);
				end
			end
			no_end = 1'b0;
			case ($urandom_range(0, 11))
				0: begin
					idx = $urandom_range(0, infix.size());
					infix.insert(idx, $urandom_range(0, 1) ? CH_LPAR : CH_RPAR);
				end
				1: begin
					idx = $urandom_range(0, infix.size() - 1);
					infix.delete(idx);
				end
				2: no_end = 1'b1;
				default: ;
			endcase
			for (int k = infix.size() - 1; k >= 0; k--)
				feed(1'b0, infix[k], added);
			if (!no_end)
				feed(1'b1, 8'($urandom_range(0, 255)), added);
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (prefix_q.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		$display("%0d words in (%0d directed), %0d words out", n_items, rnd_start, n_results);
		$display("stack overflows hit %0d times, underflow or unmatched '(' %0d times",
			n_ovf, n_unf);
		if (n_bad == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
